>>> rtl/dvfs_thermal_power_policy_defines.svh
// Assertion macros for the checker file.
`ifndef DVFS_THERMAL_POWER_POLICY_DEFINES_SVH
`define DVFS_THERMAL_POWER_POLICY_DEFINES_SVH

// Checked at every rising edge outside reset.
`define DTPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define DTPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dtpp_pkg.sv
`timescale 1ns / 1ps

package dtpp_pkg;

  localparam int POINT_ENTRIES = 8;
  localparam int PIDX_W = (POINT_ENTRIES > 1) ? $clog2(POINT_ENTRIES) : 1;
  localparam int PCNT_W = $clog2(POINT_ENTRIES + 1);

  localparam int MAX_RES = 4;
  localparam int SLOT_W = $clog2(MAX_RES);
  localparam int RES_W = $clog2(MAX_RES + 1);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [6:0] LOAD_MAX = 7'd100;
  localparam logic [6:0] LOAD_UP = 7'd80;
  localparam logic [6:0] LOAD_DOWN = 7'd20;

  localparam logic [2:0] CFG_CRIT = 3'd0;
  localparam logic [2:0] CFG_THROTTLE = 3'd1;
  localparam logic [2:0] CFG_RESUME = 3'd2;
  localparam logic [2:0] CFG_TVOLT = 3'd3;
  localparam logic [2:0] CFG_VCORE = 3'd4;
  localparam logic [2:0] CFG_IO = 3'd5;

  localparam logic [2:0] PS_ACTIVE = 3'd0;
  localparam logic [2:0] PS_BALANCED = 3'd1;
  localparam logic [2:0] PS_POWERSAVE = 3'd2;
  localparam logic [2:0] PS_SLEEP = 3'd3;
  localparam logic [2:0] PS_SHUTDOWN = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SET    = 3'd1,
    OP_PSTATE = 3'd2,
    OP_LOAD   = 3'd3,
    OP_THERM  = 3'd4,
    OP_WAKE   = 3'd5,
    OP_NOP    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ACT_SET_MV  = 3'd0,
    ACT_IO_OFF  = 3'd1,
    ACT_IO_ON   = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_SLEEP   = 3'd4,
    ACT_WAKE    = 3'd5,
    ACT_DONE    = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    MV_ZERO     = 2'd0,
    MV_TABLE    = 2'd1,
    MV_THROTTLE = 2'd2
  } mvsel_t;

  typedef struct packed {
    op_t               op;
    logic [15:0]       freq;
    logic [15:0]       volt;
    logic [2:0]        idx;
    logic [2:0]        req;
    logic [6:0]        load;
    logic signed [7:0] temp;
  } cmd_t;

  typedef struct packed {
    logic        avail;
    cmd_t        cmd;
  } cq_t;

  typedef struct packed {
    logic signed [7:0] crit;
    logic signed [7:0] throttle;
    logic signed [7:0] resume;
    logic [15:0]       tvolt;
    logic              vcore;
    logic              io;
  } cfg_t;

  typedef struct packed {
    act_t   act;
    mvsel_t mv;
  } slot_t;

endpackage

>>> rtl/dtpp_front.sv
`timescale 1ns / 1ps

module dtpp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_op,
  input  logic [15:0]       in_opp_freq_mhz,
  input  logic [15:0]       in_opp_voltage_mv,
  input  logic [2:0]        in_opp_index,
  input  logic [2:0]        in_power_state_req,
  input  logic [6:0]        in_load_percent,
  input  logic signed [7:0] in_temperature_c,
  output dtpp_pkg::cq_t     cq,
  input  logic              cq_pop
);

  dtpp_pkg::cmd_t                 cmd_dec;
  dtpp_pkg::cmd_t                 q_r [dtpp_pkg::CQ_DEPTH];
  logic [dtpp_pkg::CQ_PTR_W-1:0]  wptr_r;
  logic [dtpp_pkg::CQ_PTR_W-1:0]  rptr_r;
  logic [dtpp_pkg::CQ_CNT_W-1:0]  cnt_r;
  logic                           push_acc;
  logic                           pop_acc;

  // Unknown operations become a no-op, and load samples saturate here.
  always_comb begin
    if (in_op <= 3'(dtpp_pkg::OP_WAKE)) begin
      cmd_dec.op = dtpp_pkg::op_t'(in_op);
    end else begin
      cmd_dec.op = dtpp_pkg::OP_NOP;
    end
    cmd_dec.freq = in_opp_freq_mhz;
    cmd_dec.volt = in_opp_voltage_mv;
    cmd_dec.idx  = in_opp_index;
    cmd_dec.req  = in_power_state_req;
    cmd_dec.load = (in_load_percent > dtpp_pkg::LOAD_MAX) ? dtpp_pkg::LOAD_MAX
                                                          : in_load_percent;
    cmd_dec.temp = in_temperature_c;
  end

  assign in_full  = (cnt_r == dtpp_pkg::CQ_CNT_W'(dtpp_pkg::CQ_DEPTH));
  assign push_acc = in_push && !in_full;
  assign pop_acc  = cq_pop && (cnt_r != '0);

  assign cq.avail = (cnt_r != '0);
  assign cq.cmd   = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_acc) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop_acc) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push_acc && !pop_acc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_acc && !push_acc) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      q_r[wptr_r] <= cmd_dec;
    end
  end

endmodule

>>> rtl/dtpp_back.sv
`timescale 1ns / 1ps

module dtpp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtpp_pkg::cfg_t       cfg,
  input  dtpp_pkg::cq_t        cq,
  output logic                 cq_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_action,
  output logic [15:0]          out_voltage_mv,
  output logic [1:0]           out_status,
  output logic [2:0]           out_current_opp,
  output logic [2:0]           out_power_state,
  output logic                 out_throttled,
  output logic                 out_last
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PLAN   = 4'b0010,
    S_INSERT = 4'b0100,
    S_EMIT   = 4'b1000
  } st_t;

  st_t                                st_r;
  dtpp_pkg::cmd_t                     cur_r;
  logic [15:0]                        ftab_r [dtpp_pkg::POINT_ENTRIES];
  logic [15:0]                        vtab_r [dtpp_pkg::POINT_ENTRIES];
  logic [dtpp_pkg::PCNT_W-1:0]        cnt_r;
  logic [dtpp_pkg::PIDX_W-1:0]        pidx_r;
  logic [2:0]                         pow_r;
  logic                               thr_r;
  logic [dtpp_pkg::POINT_ENTRIES-1:0] lt_r;
  logic [15:0]                        vrd_r;
  dtpp_pkg::slot_t                    slot_r [dtpp_pkg::MAX_RES];
  logic [dtpp_pkg::SLOT_W-1:0]        lastslot_r;
  logic [dtpp_pkg::SLOT_W-1:0]        eptr_r;
  dtpp_pkg::stat_t                    stat_r;

  logic                               ovalid_r;
  dtpp_pkg::act_t                     oact_r;
  logic [15:0]                        omv_r;
  dtpp_pkg::stat_t                    ostat_r;
  logic [2:0]                         oopp_r;
  logic [2:0]                         opow_r;
  logic                               othr_r;

  // Plan of one item, worked out in the plan cycle.
  logic [dtpp_pkg::PIDX_W-1:0]        nidx;
  logic [2:0]                         npow;
  logic                               nthr;
  dtpp_pkg::stat_t                    nstat;
  logic                               sel_req;
  logic [dtpp_pkg::PCNT_W-1:0]        sel_i;
  logic [dtpp_pkg::PIDX_W-1:0]        rd_addr;
  logic                               f_iooff;
  logic                               f_ioon;
  logic                               f_restore;
  logic                               f_tblmv;
  logic                               f_thrmv;
  logic                               f_sleep;
  logic                               f_wake;
  dtpp_pkg::slot_t                    sl [dtpp_pkg::MAX_RES];
  logic [dtpp_pkg::RES_W-1:0]         n;
  logic [dtpp_pkg::POINT_ENTRIES-1:0] lt;
  logic [dtpp_pkg::PCNT_W-1:0]        pos;
  logic                               emit_go;
  dtpp_pkg::slot_t                    eslot;

  always_comb begin
    nidx      = pidx_r;
    npow      = pow_r;
    nthr      = thr_r;
    nstat     = dtpp_pkg::STAT_OK;
    sel_req   = 1'b0;
    sel_i     = '0;
    rd_addr   = '0;
    f_iooff   = 1'b0;
    f_ioon    = 1'b0;
    f_restore = 1'b0;
    f_tblmv   = 1'b0;
    f_thrmv   = 1'b0;
    f_sleep   = 1'b0;
    f_wake    = 1'b0;
    unique case (cur_r.op)
      dtpp_pkg::OP_ADD: begin
        if (cnt_r == dtpp_pkg::PCNT_W'(dtpp_pkg::POINT_ENTRIES)) begin
          nstat = dtpp_pkg::STAT_FULL;
        end
      end
      dtpp_pkg::OP_SET: begin
        if (32'(cur_r.idx) >= 32'(cnt_r)) begin
          nstat = dtpp_pkg::STAT_RANGE;
        end else begin
          sel_req = 1'b1;
          sel_i   = dtpp_pkg::PCNT_W'(cur_r.idx);
        end
      end
      dtpp_pkg::OP_PSTATE: begin
        if (cur_r.req <= dtpp_pkg::PS_SHUTDOWN) begin
          npow = cur_r.req;
          priority if (cur_r.req == dtpp_pkg::PS_ACTIVE) begin
            sel_req = (cnt_r != '0);
            sel_i   = cnt_r - 1'b1;
          end else if (cur_r.req == dtpp_pkg::PS_BALANCED) begin
            sel_req = (cnt_r > dtpp_pkg::PCNT_W'(1));
            sel_i   = cnt_r >> 1;
          end else if (cur_r.req == dtpp_pkg::PS_POWERSAVE) begin
            sel_req = 1'b1;
            sel_i   = '0;
          end else if (cur_r.req == dtpp_pkg::PS_SLEEP) begin
            f_iooff = cfg.io;
            f_tblmv = cfg.vcore && (cnt_r != '0);
            f_sleep = 1'b1;
          end else begin
            npow = cur_r.req;
          end
        end
      end
      dtpp_pkg::OP_LOAD: begin
        if ((cnt_r != '0) && !thr_r) begin
          if ((cur_r.load > dtpp_pkg::LOAD_UP) &&
              ((dtpp_pkg::PCNT_W'(pidx_r) + 1'b1) < cnt_r)) begin
            sel_req = 1'b1;
            sel_i   = dtpp_pkg::PCNT_W'(pidx_r) + 1'b1;
          end else if ((cur_r.load < dtpp_pkg::LOAD_DOWN) && (pidx_r != '0)) begin
            sel_req = 1'b1;
            sel_i   = dtpp_pkg::PCNT_W'(pidx_r) - 1'b1;
          end
        end
      end
      dtpp_pkg::OP_THERM: begin
        if (cur_r.temp >= cfg.crit) begin
          npow = dtpp_pkg::PS_SHUTDOWN;
        end else if ((cur_r.temp >= cfg.throttle) && !thr_r) begin
          nthr    = 1'b1;
          sel_req = 1'b1;
          sel_i   = '0;
          f_thrmv = cfg.vcore && (cfg.tvolt != '0);
        end else if ((cur_r.temp <= cfg.resume) && thr_r) begin
          nthr = 1'b0;
        end
      end
      dtpp_pkg::OP_WAKE: begin
        f_ioon    = cfg.io;
        f_restore = 1'b1;
        f_wake    = 1'b1;
      end
      default: begin
        nstat = dtpp_pkg::STAT_OK;
      end
    endcase

    if (sel_req && (sel_i < cnt_r)) begin
      nidx    = dtpp_pkg::PIDX_W'(sel_i);
      rd_addr = dtpp_pkg::PIDX_W'(sel_i);
      f_tblmv = cfg.vcore;
    end

    for (int k = 0; k < dtpp_pkg::MAX_RES; k++) begin
      sl[k] = '{dtpp_pkg::ACT_DONE, dtpp_pkg::MV_ZERO};
    end
    n = '0;
    if (f_iooff) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_IO_OFF, dtpp_pkg::MV_ZERO};
      n = n + 1'b1;
    end
    if (f_ioon) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_IO_ON, dtpp_pkg::MV_ZERO};
      n = n + 1'b1;
    end
    if (f_restore) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_RESTORE, dtpp_pkg::MV_ZERO};
      n = n + 1'b1;
    end
    if (f_tblmv) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_SET_MV, dtpp_pkg::MV_TABLE};
      n = n + 1'b1;
    end
    if (f_thrmv) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_SET_MV, dtpp_pkg::MV_THROTTLE};
      n = n + 1'b1;
    end
    if (f_sleep) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_SLEEP, dtpp_pkg::MV_ZERO};
      n = n + 1'b1;
    end
    if (f_wake) begin
      sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_WAKE, dtpp_pkg::MV_ZERO};
      n = n + 1'b1;
    end
    sl[n[dtpp_pkg::SLOT_W-1:0]] = '{dtpp_pkg::ACT_DONE, dtpp_pkg::MV_ZERO};
  end

  always_comb begin
    for (int i = 0; i < dtpp_pkg::POINT_ENTRIES; i++) begin
      lt[i] = (dtpp_pkg::PCNT_W'(i) < cnt_r) && (cur_r.freq < ftab_r[i]);
    end
  end

  // The new point goes before the first stored point of higher frequency.
  always_comb begin
    pos = cnt_r;
    for (int i = dtpp_pkg::POINT_ENTRIES - 1; i >= 0; i--) begin
      if (lt_r[i]) begin
        pos = dtpp_pkg::PCNT_W'(i);
      end
    end
  end

  assign cq_pop  = (st_r == S_IDLE) && cq.avail;
  assign emit_go = (st_r == S_EMIT) && (!ovalid_r || out_pop);
  assign eslot   = slot_r[eptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      pidx_r   <= '0;
      pow_r    <= dtpp_pkg::PS_ACTIVE;
      thr_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        ovalid_r <= 1'b1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (cq.avail) begin
            st_r <= S_PLAN;
          end
        end
        S_PLAN: begin
          pidx_r <= nidx;
          pow_r  <= npow;
          thr_r  <= nthr;
          if ((cur_r.op == dtpp_pkg::OP_ADD) && (nstat == dtpp_pkg::STAT_OK)) begin
            st_r <= S_INSERT;
          end else begin
            st_r <= S_EMIT;
          end
        end
        S_INSERT: begin
          cnt_r <= cnt_r + 1'b1;
          st_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go && (eptr_r == lastslot_r)) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cur_r <= cq.cmd;
    end
    if (st_r == S_PLAN) begin
      lt_r       <= lt;
      vrd_r      <= vtab_r[rd_addr];
      slot_r     <= sl;
      lastslot_r <= n[dtpp_pkg::SLOT_W-1:0];
      eptr_r     <= '0;
      stat_r     <= nstat;
    end else if (emit_go) begin
      eptr_r <= eptr_r + 1'b1;
    end
    if (st_r == S_INSERT) begin
      for (int i = 1; i < dtpp_pkg::POINT_ENTRIES; i++) begin
        if (dtpp_pkg::PCNT_W'(i) == pos) begin
          ftab_r[i] <= cur_r.freq;
          vtab_r[i] <= cur_r.volt;
        end else if ((dtpp_pkg::PCNT_W'(i) > pos) && (dtpp_pkg::PCNT_W'(i) <= cnt_r)) begin
          ftab_r[i] <= ftab_r[i-1];
          vtab_r[i] <= vtab_r[i-1];
        end
      end
      if (pos == '0) begin
        ftab_r[0] <= cur_r.freq;
        vtab_r[0] <= cur_r.volt;
      end
    end
    if (emit_go) begin
      oact_r <= eslot.act;
      unique case (eslot.mv)
        dtpp_pkg::MV_TABLE:    omv_r <= vrd_r;
        dtpp_pkg::MV_THROTTLE: omv_r <= cfg.tvolt;
        default:               omv_r <= '0;
      endcase
      ostat_r <= (eslot.act == dtpp_pkg::ACT_DONE) ? stat_r : dtpp_pkg::STAT_OK;
      oopp_r  <= 3'(pidx_r);
      opow_r  <= pow_r;
      othr_r  <= thr_r;
    end
  end

  assign out_empty       = !ovalid_r;
  assign out_action      = oact_r;
  assign out_voltage_mv  = omv_r;
  assign out_status      = ostat_r;
  assign out_current_opp = oopp_r;
  assign out_power_state = opow_r;
  assign out_throttled   = othr_r;
  assign out_last        = (oact_r == dtpp_pkg::ACT_DONE);

endmodule

>>> rtl/dvfs_thermal_power_policy.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// cfg       cfg_we             cfg_addr, cfg_wdata
// in        in_push / in_full  in_op and the operation fields
// out       out_empty / out_pop out_action and the result fields
//
// An item waits in the command queue, is planned, passes through a table
// insert when it adds a point, then emits its results one by one, each held
// while the last result is not popped; the executor handles one item at a time.
// Reset is synchronous and clears the point count, the current point, the
// power state, the throttle flag and the queues.
// The input stalls only when the two-entry command queue is full; a held
// result blocks only further results.

module dvfs_thermal_power_policy (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_op,
  input  logic [15:0]       in_opp_freq_mhz,
  input  logic [15:0]       in_opp_voltage_mv,
  input  logic [2:0]        in_opp_index,
  input  logic [2:0]        in_power_state_req,
  input  logic [6:0]        in_load_percent,
  input  logic signed [7:0] in_temperature_c,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [2:0]        out_action,
  output logic [15:0]       out_voltage_mv,
  output logic [1:0]        out_status,
  output logic [2:0]        out_current_opp,
  output logic [2:0]        out_power_state,
  output logic              out_throttled,
  output logic              out_last
);

  dtpp_pkg::cfg_t cfg_r;
  dtpp_pkg::cq_t  cq;
  logic           cq_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crit     <= 8'sd110;
      cfg_r.throttle <= 8'sd90;
      cfg_r.resume   <= 8'sd80;
      cfg_r.tvolt    <= '0;
      cfg_r.vcore    <= 1'b1;
      cfg_r.io       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dtpp_pkg::CFG_CRIT:     cfg_r.crit     <= cfg_wdata[7:0];
        dtpp_pkg::CFG_THROTTLE: cfg_r.throttle <= cfg_wdata[7:0];
        dtpp_pkg::CFG_RESUME:   cfg_r.resume   <= cfg_wdata[7:0];
        dtpp_pkg::CFG_TVOLT:    cfg_r.tvolt    <= cfg_wdata;
        dtpp_pkg::CFG_VCORE:    cfg_r.vcore    <= cfg_wdata[0];
        dtpp_pkg::CFG_IO:       cfg_r.io       <= cfg_wdata[0];
        default:                cfg_r          <= cfg_r;
      endcase
    end
  end

  dtpp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_op              (in_op),
    .in_opp_freq_mhz    (in_opp_freq_mhz),
    .in_opp_voltage_mv  (in_opp_voltage_mv),
    .in_opp_index       (in_opp_index),
    .in_power_state_req (in_power_state_req),
    .in_load_percent    (in_load_percent),
    .in_temperature_c   (in_temperature_c),
    .cq                 (cq),
    .cq_pop             (cq_pop)
  );

  dtpp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cq              (cq),
    .cq_pop          (cq_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_action      (out_action),
    .out_voltage_mv  (out_voltage_mv),
    .out_status      (out_status),
    .out_current_opp (out_current_opp),
    .out_power_state (out_power_state),
    .out_throttled   (out_throttled),
    .out_last        (out_last)
  );

endmodule

>>> rtl/dtpp_checker.sv
`timescale 1ns / 1ps
`include "dvfs_thermal_power_policy_defines.svh"

module dtpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_action,
  input logic [15:0] out_voltage_mv,
  input logic [1:0]  out_status,
  input logic        out_last
);

  `DTPP_ASSERT(a_last_on_done,
               !out_empty |-> (out_last == (out_action == dtpp_pkg::ACT_DONE)),
               "last must mark exactly the done item")
  `DTPP_ASSERT(a_status_on_done,
               (!out_empty && out_action != dtpp_pkg::ACT_DONE) |->
                 (out_status == dtpp_pkg::STAT_OK),
               "status set on an item other than done")
  `DTPP_ASSERT(a_mv_only_set,
               (!out_empty && out_action != dtpp_pkg::ACT_SET_MV) |->
                 (out_voltage_mv == 16'd0),
               "voltage on an item that is not a voltage command")
  `DTPP_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> out_empty,
                      "result queue not empty after reset")
  `DTPP_ASSERT(a_stall_hold,
               (!out_empty && !out_pop) |=> (!out_empty && $stable(out_action)),
               "waiting result changed while stalled")

endmodule

bind dvfs_thermal_power_policy dtpp_checker u_dtpp_checker (.*);
